// ----- sv/bsp_pkg.sv -----
`default_nettype none

package bsp_pkg;

    // Number of header bytes that precede the facet count.
    localparam logic [6:0] HEADER_BYTES = 7'd80;

    // Byte positions inside one 50-byte facet record.
    localparam logic [6:0] FACET_FLOAT_BYTES = 7'd48;
    localparam logic [6:0] FACET_LAST_FLOAT  = 7'd47;
    localparam logic [6:0] FACET_ATTR0       = 7'd48;
    localparam logic [6:0] FACET_ATTR1       = 7'd49;

    // Result status codes.
    localparam logic [2:0] ST_VERTEX       = 3'd0;
    localparam logic [2:0] ST_ALL_READ     = 3'd1;
    localparam logic [2:0] ST_HEADER_SHORT = 3'd2;
    localparam logic [2:0] ST_NON_FINITE   = 3'd3;
    localparam logic [2:0] ST_FACET_SHORT  = 3'd4;
    localparam logic [2:0] ST_ATTR_SHORT   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [1:0]  corner;
        logic [31:0] facet_index;
        logic        run_end;
    } t_out;

    // Up to two results produced by one byte, in delivery order.
    typedef struct packed {
        logic [1:0] cnt;
        t_out       res0;
        t_out       res1;
    } t_push;

endpackage

`default_nettype wire

// ----- sv/bsp_core.sv -----
`default_nettype none

module bsp_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_go,
    input  wire bsp_pkg::t_in i_byte,
    output bsp_pkg::t_push    o_push
);
    import bsp_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_FACET  = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [6:0]  r_pos,    n_pos;
    logic [31:0] r_left,   n_left;
    logic [31:0] r_fcnt,   n_fcnt;
    logic [23:0] r_part,   n_part;
    logic [31:0] r_hx,     n_hx;
    logic [31:0] r_hy,     n_hy;

    logic [31:0] word;
    logic        non_finite;
    logic        last;
    logic [6:0]  hdr_off;
    logic [1:0]  lane;
    t_push       push;

    function automatic logic [23:0] merge(input logic [23:0] part, input logic [7:0] b,
                                          input logic [1:0] ln);
        logic [23:0] r;
        begin
            case (ln)
                2'd0:    r = part | {16'd0, b};
                2'd1:    r = part | {8'd0, b, 8'd0};
                2'd2:    r = part | {b, 16'd0};
                default: r = part;
            endcase
            return r;
        end
    endfunction

    function automatic t_out mk_status(input logic [2:0] st, input logic [31:0] fi);
        t_out r;
        begin
            r             = '0;
            r.status      = st;
            r.facet_index = fi;
            return r;
        end
    endfunction

    assign word       = {i_byte.data_byte, r_part};
    assign non_finite = &word[30:23];
    assign last       = i_byte.stream_end;
    assign hdr_off    = r_pos - HEADER_BYTES;
    assign lane       = r_pos[1:0];

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_left  = r_left;
        n_fcnt  = r_fcnt;
        n_part  = r_part;
        n_hx    = r_hx;
        n_hy    = r_hy;
        push    = '0;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos < HEADER_BYTES) begin
                    n_pos = r_pos + 7'd1;
                    if (last) begin
                        push.res0 = mk_status(ST_HEADER_SHORT, 32'd0);
                        push.cnt  = 2'd1;
                        n_phase   = PH_ERROR;
                    end
                end else if (hdr_off[1:0] != 2'd3) begin
                    n_part = merge(r_part, i_byte.data_byte, hdr_off[1:0]);
                    n_pos  = r_pos + 7'd1;
                    if (last) begin
                        push.res0 = mk_status(ST_HEADER_SHORT, 32'd0);
                        push.cnt  = 2'd1;
                        n_phase   = PH_ERROR;
                    end
                end else begin
                    n_left = word;
                    n_part = '0;
                    n_pos  = '0;
                    if (word == 32'd0) begin
                        push.res0 = mk_status(ST_ALL_READ, r_fcnt);
                        push.cnt  = 2'd1;
                        n_phase   = PH_DONE;
                    end else if (last) begin
                        push.res0 = mk_status(ST_FACET_SHORT, r_fcnt);
                        push.cnt  = 2'd1;
                        n_phase   = PH_ERROR;
                    end else begin
                        n_phase = PH_FACET;
                    end
                end
            end
            PH_FACET: begin
                if (r_pos < FACET_FLOAT_BYTES) begin
                    if (lane != 2'd3) begin
                        n_part = merge(r_part, i_byte.data_byte, lane);
                    end else begin
                        n_part = '0;
                        if (!non_finite) begin
                            // Word number r_pos[5:2]: 0..2 are the normal, then x, y, z
                            // for each of the three corners.
                            case (r_pos[5:2])
                                4'd3, 4'd6, 4'd9:  n_hx = word;
                                4'd4, 4'd7, 4'd10: n_hy = word;
                                4'd5, 4'd8, 4'd11: begin
                                    push.res0.status      = ST_VERTEX;
                                    push.res0.x_bits      = r_hx;
                                    push.res0.y_bits      = r_hy;
                                    push.res0.z_bits      = word;
                                    push.res0.facet_index = r_fcnt;
                                    push.cnt              = 2'd1;
                                    if (r_pos[5:2] == 4'd8) begin
                                        push.res0.corner = 2'd1;
                                    end else if (r_pos[5:2] == 4'd11) begin
                                        push.res0.corner = 2'd2;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end

                    if (lane == 2'd3 && non_finite) begin
                        // A bad float wins over truncation on the same byte.
                        push.res0 = mk_status(ST_NON_FINITE, r_fcnt);
                        push.cnt  = 2'd1;
                        n_phase   = PH_ERROR;
                        n_pos     = '0;
                    end else begin
                        n_pos = r_pos + 7'd1;
                        if (last) begin
                            n_phase = PH_ERROR;
                            if (push.cnt == 2'd1) begin
                                push.res1 = mk_status((r_pos == FACET_LAST_FLOAT) ?
                                                      ST_ATTR_SHORT : ST_FACET_SHORT,
                                                      r_fcnt);
                                push.cnt  = 2'd2;
                            end else begin
                                push.res0 = mk_status((r_pos == FACET_LAST_FLOAT) ?
                                                      ST_ATTR_SHORT : ST_FACET_SHORT,
                                                      r_fcnt);
                                push.cnt  = 2'd1;
                            end
                        end
                    end
                end else if (r_pos == FACET_ATTR0) begin
                    n_pos = FACET_ATTR1;
                    if (last) begin
                        push.res0 = mk_status(ST_ATTR_SHORT, r_fcnt);
                        push.cnt  = 2'd1;
                        n_phase   = PH_ERROR;
                    end
                end else begin
                    n_pos  = '0;
                    n_fcnt = r_fcnt + 32'd1;
                    n_left = r_left - 32'd1;
                    if (r_left == 32'd1) begin
                        push.res0 = mk_status(ST_ALL_READ, r_fcnt + 32'd1);
                        push.cnt  = 2'd1;
                        n_phase   = PH_DONE;
                    end else if (last) begin
                        push.res0 = mk_status(ST_FACET_SHORT, r_fcnt + 32'd1);
                        push.cnt  = 2'd1;
                        n_phase   = PH_ERROR;
                    end
                end
            end
            default: begin
            end
        endcase

        if (push.cnt == 2'd1) begin
            push.res0.run_end = 1'b1;
        end else if (push.cnt == 2'd2) begin
            push.res1.run_end = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_left  <= '0;
            r_fcnt  <= '0;
            r_part  <= '0;
            r_hx    <= '0;
            r_hy    <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_fcnt  <= n_fcnt;
            r_part  <= n_part;
            r_hx    <= n_hx;
            r_hy    <= n_hy;
        end
    end

    assign o_push = i_go ? push : '0;

endmodule

`default_nettype wire

// ----- sv/bsp_out_fifo.sv -----
`default_nettype none

module bsp_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bsp_pkg::t_push i_push,
    output logic                o_room2,
    output logic                o_valid,
    input  wire logic           i_stall,
    output bsp_pkg::t_out       o_data
);
    import bsp_pkg::*;

    t_out       r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign o_room2 = (r_cnt <= 3'd2);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push.cnt;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push.cnt} - {2'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ----- sv/binary_stl_stream_parser.sv -----
// Streaming parser for binary triangle-mesh files, one byte per request.
// Input channel: i_in_valid / o_in_stall carry one byte and an end-of-stream
// flag per request. Output channel: o_out_valid / i_out_stall carry one result
// per request: a vertex (three raw float words, corner, facet number) or a
// status report (all facets read, header short, non-finite, facet short,
// attribute short). A byte causes zero, one or two results; run_end marks the
// last result of a byte.
// Throughput: one byte per cycle while the receiver takes results. A byte is
// held in the input register, then the parser updates its state and writes
// its results into a four-entry result queue; the earliest result then appears
// on the output and is taken when the receiver does not stall.
// The parser consumes a byte only when the queue has room for two results, so
// a stalled receiver backs up into the input register and then into o_in_stall.
// Reset clears the parser to the start of the header and empties the queue.
// After completion or an error every further byte is accepted and dropped.
`default_nettype none

module binary_stl_stream_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bsp_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bsp_pkg::t_out      o_out_data
);
    import bsp_pkg::*;

    // Input register: holds one byte until the parser can take it.
    logic  r_in_valid, n_in_valid;
    t_in   r_in;
    logic  accept;
    logic  go;
    logic  room2;
    t_push push;

    assign go         = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept || (r_in_valid && !go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Parser state and per-byte decode.
    bsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in),
        .o_push  (push)
    );

    // Result queue in front of the receiver.
    bsp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire
